>>> design/safq_pkg.sv
package safq_pkg;

  // Command codes of a request.
  localparam logic [1:0] CMD_CONNECT    = 2'd0;
  localparam logic [1:0] CMD_DISCONNECT = 2'd1;
  localparam logic [1:0] CMD_INVALIDATE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request fields
    logic exec;     // memory read data is valid, apply the request
    logic clear;    // write one cleared map entry
  } ctrl_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic is_inval;    // captured request is an invalidate
    logic clear_last;  // clear pointer is on the last map entry
  } stat_t;

endpackage

>>> design/safq_ctrl.sv
module safq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  safq_pkg::stat_t stat,
  output safq_pkg::ctrl_t ctrl,
  output logic            busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    ctrl.capture = 1'b0;
    ctrl.exec    = 1'b0;
    ctrl.clear   = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.capture = 1'b1;
          state_next   = S_READ;
        end
      end
      S_READ: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        ctrl.exec  = 1'b1;
        state_next = stat.is_inval ? S_CLEAR : S_IDLE;
      end
      S_CLEAR: begin
        ctrl.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

>>> design/safq_datapath.sv
module safq_datapath #(
  parameter int NODE_COUNT  = 1024,
  parameter int SLOT_COUNT  = 256,
  parameter int ENTRY_WIDTH = 48,
  parameter int NODE_W      = $clog2(NODE_COUNT),
  parameter int SLOT_W      = $clog2(SLOT_COUNT)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  safq_pkg::ctrl_t        ctrl,
  output safq_pkg::stat_t        stat,
  input  logic [1:0]             command,
  input  logic                   is_leaf,
  input  logic [NODE_W-1:0]      node_index,
  input  logic [ENTRY_WIDTH-1:0] entry_data,
  output logic                   done,
  output logic [1:0]             status,
  output logic [SLOT_W-1:0]      slot,
  output logic                   reused
);

  localparam logic [SLOT_W:0]   SlotCountC = (SLOT_W+1)'(SLOT_COUNT);
  localparam logic [NODE_W-1:0] NodeLastC  = NODE_W'(NODE_COUNT - 1);
  localparam logic [SLOT_W-1:0] SlotLastC  = SLOT_W'(SLOT_COUNT - 1);

  // Map entry: valid flag on top of the slot number.
  logic [SLOT_W:0]      map_mem [NODE_COUNT];
  logic [SLOT_W-1:0]    fq_mem [SLOT_COUNT];
  logic [ENTRY_WIDTH-1:0] store_mem [SLOT_COUNT];

  logic [1:0]             cmd_q;
  logic                   leaf_q;
  logic [NODE_W-1:0]      node_q;
  logic [ENTRY_WIDTH-1:0] data_q;

  logic [SLOT_W:0]   map_rd;
  logic [SLOT_W-1:0] fq_rd;

  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] head_next;
  logic [SLOT_W:0]   count;
  logic [SLOT_W:0]   count_next;
  logic [SLOT_W:0]   appended;
  logic [SLOT_W:0]   appended_next;
  logic [NODE_W-1:0] clr_cnt;

  logic [SLOT_W:0]   tail_sum;
  logic [SLOT_W-1:0] tail;

  logic              map_we;
  logic              map_wr_valid;
  logic              fq_we;
  logic              store_we;
  logic [SLOT_W-1:0] slot_sel;
  logic [1:0]        status_next;
  logic [SLOT_W-1:0] slot_out;
  logic              reused_next;

  assign stat.is_inval   = (cmd_q == safq_pkg::CMD_INVALIDATE);
  assign stat.clear_last = (clr_cnt == NodeLastC);

  assign tail_sum = {1'b0, head} + count;
  assign tail     = (tail_sum >= SlotCountC) ? SLOT_W'(tail_sum - SlotCountC)
                                             : tail_sum[SLOT_W-1:0];

  always_comb begin
    head_next     = head;
    count_next    = count;
    appended_next = appended;
    map_we        = 1'b0;
    map_wr_valid  = 1'b0;
    fq_we         = 1'b0;
    store_we      = 1'b0;
    slot_sel      = '0;
    status_next   = safq_pkg::ST_DONE;
    slot_out      = '0;
    reused_next   = 1'b0;
    case (cmd_q)
      safq_pkg::CMD_INVALIDATE: begin
        head_next     = '0;
        count_next    = '0;
        appended_next = '0;
      end
      safq_pkg::CMD_CONNECT: begin
        if (!leaf_q) begin
          status_next = safq_pkg::ST_IGNORED;
        end else if (map_rd[SLOT_W]) begin
          status_next = safq_pkg::ST_ERROR;
        end else if (count != '0) begin
          slot_sel     = fq_rd;
          head_next    = (head == SlotLastC) ? '0 : head + 1'b1;
          count_next   = count - 1'b1;
          map_we       = 1'b1;
          map_wr_valid = 1'b1;
          store_we     = 1'b1;
          slot_out     = fq_rd;
          reused_next  = 1'b1;
        end else if (appended == SlotCountC) begin
          status_next = safq_pkg::ST_FULL;
        end else begin
          slot_sel      = appended[SLOT_W-1:0];
          appended_next = appended + 1'b1;
          map_we        = 1'b1;
          map_wr_valid  = 1'b1;
          store_we      = 1'b1;
          slot_out      = appended[SLOT_W-1:0];
        end
      end
      safq_pkg::CMD_DISCONNECT: begin
        if (!leaf_q) begin
          status_next = safq_pkg::ST_IGNORED;
        end else if (!map_rd[SLOT_W] || count == SlotCountC) begin
          status_next = safq_pkg::ST_ERROR;
        end else begin
          slot_sel   = map_rd[SLOT_W-1:0];
          map_we     = 1'b1;
          fq_we      = 1'b1;
          count_next = count + 1'b1;
          slot_out   = map_rd[SLOT_W-1:0];
        end
      end
      default: begin
        status_next = safq_pkg::ST_ERROR;
      end
    endcase
  end

  // Request capture and result registers.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q  <= command;
      leaf_q <= is_leaf;
      node_q <= node_index;
      data_q <= entry_data;
    end
    status <= status_next;
    slot   <= slot_out;
    reused <= reused_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      appended <= '0;
      clr_cnt  <= '0;
      done     <= 1'b0;
    end else begin
      done <= ctrl.exec;
      if (ctrl.exec) begin
        head     <= head_next;
        count    <= count_next;
        appended <= appended_next;
        clr_cnt  <= '0;
      end else if (ctrl.clear) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Map memory: one write port shared by clearing and updates, one read port.
  always_ff @(posedge clk) begin
    map_rd <= map_mem[node_q];
    if (ctrl.clear) begin
      map_mem[clr_cnt] <= '0;
    end else if (ctrl.exec && map_we) begin
      map_mem[node_q] <= {map_wr_valid, slot_sel};
    end
  end

  // Free slot ring.
  always_ff @(posedge clk) begin
    fq_rd <= fq_mem[head];
    if (ctrl.exec && fq_we) begin
      fq_mem[tail] <= slot_sel;
    end
  end

  // Per-slot entry payload.
  always_ff @(posedge clk) begin
    if (ctrl.exec && store_we) begin
      store_mem[slot_sel] <= data_q;
    end
  end

endmodule

>>> design/slot_allocator_with_free_queue_unit.sv
// Channel   | Handshake            | Fields
// ----------+----------------------+----------------------------------------------
// request   | start high, busy low | command, is_leaf, node_index, entry_data
// result    | done strobe (1 cycle)| status, slot, reused
//
// A request passes through an accept cycle, a cycle in which the node map and
// the free slot ring are read, and a cycle that applies the request and writes the
// memories; busy is high after the accept. The registered result strobe comes in
// the cycle after, when a new request may be taken, except after an invalidate.
// After reset, and after every invalidate, the node map is cleared one entry per
// cycle, all NODE_COUNT entries, while busy stays high. The receiver cannot stall.
module slot_allocator_with_free_queue_unit #(
  parameter int NODE_COUNT  = 1024,
  parameter int SLOT_COUNT  = 256,
  parameter int ENTRY_WIDTH = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    command,
  input  logic                          is_leaf,
  input  logic [$clog2(NODE_COUNT)-1:0] node_index,
  input  logic [ENTRY_WIDTH-1:0]        entry_data,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [$clog2(SLOT_COUNT)-1:0] slot,
  output logic                          reused
);

  // The controller sequences each request; the datapath holds the node map,
  // the free slot ring, the payload store and the allocation counters.
  safq_pkg::ctrl_t ctrl;
  safq_pkg::stat_t stat;

  safq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  safq_datapath #(
    .NODE_COUNT  (NODE_COUNT),
    .SLOT_COUNT  (SLOT_COUNT),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .stat       (stat),
    .command    (command),
    .is_leaf    (is_leaf),
    .node_index (node_index),
    .entry_data (entry_data),
    .done       (done),
    .status     (status),
    .slot       (slot),
    .reused     (reused)
  );

endmodule
